@@ src/utf8e_pkg.sv @@
// shared types and constants for the utf-32 to utf-8 encoder
package utf8e_pkg;

	localparam int LANES       = 8;
	localparam int CHUNK_BYTES = 8;
	localparam int CP_W        = 21;
	localparam int COUNT_W     = 4;
	localparam int LEN_W       = 3;
	localparam int MAX_BYTES   = LANES * 4;
	localparam int TOTAL_W     = $clog2(MAX_BYTES + 1);
	localparam int BYTE_IDX_W  = $clog2(MAX_BYTES);
	localparam int CHUNK_W     = CHUNK_BYTES * 8;

	localparam logic [7:0] CONT_MARK = 8'h80;
	localparam logic [7:0] LEAD2     = 8'hC0;
	localparam logic [7:0] LEAD3     = 8'hE0;
	localparam logic [7:0] LEAD4     = 8'hF0;

	typedef struct packed {
		logic [CP_W-1:0]    code_point_0;
		logic [CP_W-1:0]    code_point_1;
		logic [CP_W-1:0]    code_point_2;
		logic [CP_W-1:0]    code_point_3;
		logic [CP_W-1:0]    code_point_4;
		logic [CP_W-1:0]    code_point_5;
		logic [CP_W-1:0]    code_point_6;
		logic [CP_W-1:0]    code_point_7;
		logic [COUNT_W-1:0] lane_count;
	} group_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [COUNT_W-1:0] chunk_count;
		logic               last_chunk;
	} chunk_t;

	typedef struct packed {
		logic [3:0][7:0]  bytes;
		logic [LEN_W-1:0] len;
	} lane_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [TOTAL_W-1:0]        total;
	} group_buf_t;

endpackage

@@ src/utf8e_if.sv @@
// stream interfaces for code point groups and utf-8 chunks
interface utf8e_group_if;
	logic              valid;
	logic              ready;
	utf8e_pkg::group_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface utf8e_chunk_if;
	logic              valid;
	logic              ready;
	utf8e_pkg::chunk_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ src/utf32_to_utf8_encoder_core.sv @@
// top level of the utf-32 to utf-8 encoder
// a group passes the lane, packed group, emitter hold and output registers in order
// each group gives ceil(bytes / 8) chunks, 1 to 4, one per cycle while the receiver
// takes them, from the emitter output register; the next group loads as the last
// chunk leaves; groups with a lane count of zero produce no chunk
// reset: asynchronous, clears all stage valid flags; data registers are not reset
module utf32_to_utf8_encoder_core (
	input  logic          clk,
	input  logic          arst_n,
	utf8e_group_if.sink   points,
	utf8e_chunk_if.source chunks
);

	logic [utf8e_pkg::LANES-1:0][utf8e_pkg::CP_W-1:0] cp;
	logic [utf8e_pkg::COUNT_W-1:0]                    lanes_sat;
	utf8e_pkg::lane_t [utf8e_pkg::LANES-1:0]          lane_enc;
	utf8e_pkg::lane_t [utf8e_pkg::LANES-1:0]          lane_s1;
	logic                                             valid_s1;
	utf8e_pkg::group_buf_t                            packed_group;
	utf8e_pkg::group_buf_t                            group_s2;
	logic                                             valid_s2;
	logic                                             emit_ready;
	logic                                             s2_free;
	logic                                             s1_free;

	assign cp[0] = points.payload.code_point_0;
	assign cp[1] = points.payload.code_point_1;
	assign cp[2] = points.payload.code_point_2;
	assign cp[3] = points.payload.code_point_3;
	assign cp[4] = points.payload.code_point_4;
	assign cp[5] = points.payload.code_point_5;
	assign cp[6] = points.payload.code_point_6;
	assign cp[7] = points.payload.code_point_7;

	assign lanes_sat =
		(points.payload.lane_count > utf8e_pkg::COUNT_W'(utf8e_pkg::LANES))
		? utf8e_pkg::COUNT_W'(utf8e_pkg::LANES) : points.payload.lane_count;

	for (genvar i = 0; i < utf8e_pkg::LANES; i++) begin : g_lane
		utf8e_lane u_lane (
			.code_point (cp[i]),
			.active     (utf8e_pkg::COUNT_W'(i) < lanes_sat),
			.lane       (lane_enc[i])
		);
	end

	assign s2_free      = !valid_s2 || emit_ready;
	assign s1_free      = !valid_s1 || s2_free;
	assign points.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= points.valid && (points.payload.lane_count != '0);
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			lane_s1 <= lane_enc;
		end
		if (s2_free && valid_s1) begin
			group_s2 <= packed_group;
		end
	end

	utf8e_pack u_pack (
		.lanes        (lane_s1),
		.packed_group (packed_group)
	);

	utf8e_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s2),
		.load_group (group_s2),
		.load_ready (emit_ready),
		.chunks     (chunks)
	);

endmodule

@@ src/utf8e_lane.sv @@
// single lane encoder: one code point to one to four utf-8 bytes, none when inactive
module utf8e_lane (
	input  logic [utf8e_pkg::CP_W-1:0] code_point,
	input  logic                       active,
	output utf8e_pkg::lane_t           lane
);

	logic fits1;
	logic fits2;
	logic fits3;

	assign fits1 = (code_point[20:7] == '0);
	assign fits2 = (code_point[20:11] == '0);
	assign fits3 = (code_point[20:16] == '0);

	always_comb begin
		lane.bytes = '0;
		lane.len   = '0;
		if (active) begin
			if (fits1) begin
				lane.bytes[0] = code_point[7:0];
				lane.len      = 3'd1;
			end else if (fits2) begin
				lane.bytes[0] = utf8e_pkg::LEAD2 | {3'b000, code_point[10:6]};
				lane.bytes[1] = utf8e_pkg::CONT_MARK | {2'b00, code_point[5:0]};
				lane.len      = 3'd2;
			end else if (fits3) begin
				lane.bytes[0] = utf8e_pkg::LEAD3 | {4'b0000, code_point[15:12]};
				lane.bytes[1] = utf8e_pkg::CONT_MARK | {2'b00, code_point[11:6]};
				lane.bytes[2] = utf8e_pkg::CONT_MARK | {2'b00, code_point[5:0]};
				lane.len      = 3'd3;
			end else begin
				lane.bytes[0] = utf8e_pkg::LEAD4 | {5'b00000, code_point[20:18]};
				lane.bytes[1] = utf8e_pkg::CONT_MARK | {2'b00, code_point[17:12]};
				lane.bytes[2] = utf8e_pkg::CONT_MARK | {2'b00, code_point[11:6]};
				lane.bytes[3] = utf8e_pkg::CONT_MARK | {2'b00, code_point[5:0]};
				lane.len      = 3'd4;
			end
		end
	end

endmodule

@@ src/utf8e_pack.sv @@
// merge stage: offsets by running sum of lane lengths, dense byte packing
module utf8e_pack (
	input  utf8e_pkg::lane_t [utf8e_pkg::LANES-1:0] lanes,
	output utf8e_pkg::group_buf_t                   packed_group
);

	logic [utf8e_pkg::TOTAL_W-1:0]          off;
	logic [utf8e_pkg::MAX_BYTES-1:0][7:0]   packed_bytes;

	always_comb begin
		off          = '0;
		packed_bytes = '0;
		for (int i = 0; i < utf8e_pkg::LANES; i++) begin
			for (int k = 0; k < 4; k++) begin
				if (utf8e_pkg::LEN_W'(k) < lanes[i].len) begin
					packed_bytes[utf8e_pkg::BYTE_IDX_W'(off + utf8e_pkg::TOTAL_W'(k))] =
						lanes[i].bytes[k];
				end
			end
			off = off + utf8e_pkg::TOTAL_W'(lanes[i].len);
		end
	end

	assign packed_group.bytes = packed_bytes;
	assign packed_group.total = off;

endmodule

@@ src/utf8e_emit.sv @@
// chunk emitter: slices a packed group into chunks behind an output register
module utf8e_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  utf8e_pkg::group_buf_t load_group,
	output logic                  load_ready,
	utf8e_chunk_if.source         chunks
);

	logic [utf8e_pkg::MAX_BYTES-1:0][7:0] data_q;
	logic [utf8e_pkg::TOTAL_W-1:0]        remaining_q;
	logic                                 emit_valid_q;
	logic                                 out_valid_q;
	utf8e_pkg::chunk_t                    out_q;
	logic                                 emit_fire;
	logic                                 emit_last;
	logic                                 emit_free;

	assign emit_last  = (remaining_q <= utf8e_pkg::TOTAL_W'(utf8e_pkg::CHUNK_BYTES));
	assign emit_fire  = emit_valid_q && (!out_valid_q || chunks.ready);
	assign emit_free  = !emit_valid_q || (emit_fire && emit_last);
	assign load_ready = emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_free) begin
				emit_valid_q <= load_valid;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (chunks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && load_valid) begin
			data_q      <= load_group.bytes;
			remaining_q <= load_group.total;
		end else if (emit_fire) begin
			data_q      <= data_q >> utf8e_pkg::CHUNK_W;
			remaining_q <= remaining_q - utf8e_pkg::TOTAL_W'(utf8e_pkg::CHUNK_BYTES);
		end
		if (emit_fire) begin
			out_q.chunk_bytes <= data_q[utf8e_pkg::CHUNK_BYTES-1:0];
			out_q.chunk_count <= emit_last ? utf8e_pkg::COUNT_W'(remaining_q)
				: utf8e_pkg::COUNT_W'(utf8e_pkg::CHUNK_BYTES);
			out_q.last_chunk  <= emit_last;
		end
	end

	assign chunks.valid   = out_valid_q;
	assign chunks.payload = out_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.chunk_count != '0 &&
			out_q.chunk_count <= utf8e_pkg::COUNT_W'(utf8e_pkg::CHUNK_BYTES)))
		else $error("chunk count out of range");
	a_remaining_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid_q |-> (remaining_q != '0))
		else $error("emitter holds a group with no bytes left");
	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last_chunk) |->
			(out_q.chunk_count == utf8e_pkg::COUNT_W'(utf8e_pkg::CHUNK_BYTES)))
		else $error("short chunk before the last one");
	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && !emit_last) |=> emit_valid_q)
		else $error("group dropped before its last chunk");
`endif

endmodule

@@ tb/sv/utf8e_tb_pkg.sv @@
// expected chunk store and checker for the utf-32 to utf-8 encoder testbench
`timescale 1ns / 100ps
package utf8e_tb_pkg;

	class chunk_scoreboard;
		utf8e_pkg::chunk_t expected_chunks[$];
		int                errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_chunks.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40) begin
				$display("mismatch %0d: %s", errors, what);
			end
		endtask

		// encode the accepted group and split its bytes into expected chunks
		function void note(utf8e_pkg::group_t g);
			logic [utf8e_pkg::CP_W-1:0] cps [utf8e_pkg::LANES];
			logic [utf8e_pkg::CP_W-1:0] cp;
			logic [7:0]                 utf8_bytes[$];
			int                         lanes;
			int                         cnt;
			utf8e_pkg::chunk_t          c;
			cps = '{g.code_point_0, g.code_point_1, g.code_point_2, g.code_point_3,
				g.code_point_4, g.code_point_5, g.code_point_6, g.code_point_7};
			lanes = (g.lane_count > utf8e_pkg::LANES) ? utf8e_pkg::LANES
				: int'(g.lane_count);
			for (int i = 0; i < lanes; i++) begin
				cp = cps[i];
				if (cp[utf8e_pkg::CP_W-1:7] == '0) begin
					utf8_bytes.push_back(8'(cp[6:0]));
				end else if (cp[utf8e_pkg::CP_W-1:11] == '0) begin
					utf8_bytes.push_back(utf8e_pkg::LEAD2 | 8'(cp[10:6]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[5:0]));
				end else if (cp[utf8e_pkg::CP_W-1:16] == '0) begin
					utf8_bytes.push_back(utf8e_pkg::LEAD3 | 8'(cp[15:12]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[11:6]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[5:0]));
				end else begin
					utf8_bytes.push_back(utf8e_pkg::LEAD4 | 8'(cp[20:18]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[17:12]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[11:6]));
					utf8_bytes.push_back(utf8e_pkg::CONT_MARK | 8'(cp[5:0]));
				end
			end
			for (int pos = 0; pos < utf8_bytes.size(); pos += utf8e_pkg::CHUNK_BYTES) begin
				cnt = utf8_bytes.size() - pos;
				if (cnt > utf8e_pkg::CHUNK_BYTES) cnt = utf8e_pkg::CHUNK_BYTES;
				c = '0;
				for (int b = 0; b < cnt; b++) begin
					c.chunk_bytes[8*b +: 8] = utf8_bytes[pos + b];
				end
				c.chunk_count = utf8e_pkg::COUNT_W'(cnt);
				c.last_chunk  = (pos + cnt >= utf8_bytes.size());
				expected_chunks.push_back(c);
			end
		endfunction

		task check(utf8e_pkg::chunk_t got);
			utf8e_pkg::chunk_t want;
			if (expected_chunks.size() == 0) begin
				report($sformatf("chunk with no group pending: bytes=%h count=%0d last=%0b",
					got.chunk_bytes, got.chunk_count, got.last_chunk));
				return;
			end
			want = expected_chunks.pop_front();
			if (got.chunk_bytes !== want.chunk_bytes) begin
				report($sformatf("chunk_bytes %h, want %h", got.chunk_bytes, want.chunk_bytes));
			end
			if (got.chunk_count !== want.chunk_count) begin
				report($sformatf("chunk_count %0d, want %0d", got.chunk_count, want.chunk_count));
			end
			if (got.last_chunk !== want.last_chunk) begin
				report($sformatf("last_chunk %0b, want %0b", got.last_chunk, want.last_chunk));
			end
		endtask
	endclass

endpackage

@@ tb/sv/tb_top.sv @@
// top level testbench for the utf-32 to utf-8 encoder core
`timescale 1ns / 100ps
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 300;

	logic                          clk;
	logic                          arst_n;
	int                            src_idle_pct  = 0;
	int                            sink_idle_pct = 0;
	int                            hold_req      = 0;
	int                            hold_ack      = 0;
	int                            hold_cycles   = 0;
	int unsigned                   cycle_count   = 0;
	utf8e_tb_pkg::chunk_scoreboard sb;

	utf8e_group_if points_if();
	utf8e_chunk_if chunks_if();

	utf32_to_utf8_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points_if),
		.chunks (chunks_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			chunks_if.ready <= 1'b0;
			hold_ack        <= hold_req;
			hold_cycles     <= HOLD_LEN - 1;
		end else if (hold_cycles > 0) begin
			chunks_if.ready <= 1'b0;
			hold_cycles     <= hold_cycles - 1;
		end else begin
			chunks_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && points_if.valid === 1'b1 && points_if.ready === 1'b1) begin
			sb.note(points_if.payload);
		end
		if (arst_n && chunks_if.valid === 1'b1 && chunks_if.ready === 1'b1) begin
			sb.check(chunks_if.payload);
		end
	end

	function automatic utf8e_pkg::group_t make_group(
		input logic [utf8e_pkg::CP_W-1:0] cps [utf8e_pkg::LANES],
		input logic [utf8e_pkg::COUNT_W-1:0] lanes);
		utf8e_pkg::group_t g;
		g.code_point_0 = cps[0];
		g.code_point_1 = cps[1];
		g.code_point_2 = cps[2];
		g.code_point_3 = cps[3];
		g.code_point_4 = cps[4];
		g.code_point_5 = cps[5];
		g.code_point_6 = cps[6];
		g.code_point_7 = cps[7];
		g.lane_count   = lanes;
		return g;
	endfunction

	// code points spread over all four encoded lengths plus values past 0x10ffff
	function automatic utf8e_pkg::group_t random_group();
		logic [utf8e_pkg::CP_W-1:0]    cps [utf8e_pkg::LANES];
		logic [utf8e_pkg::COUNT_W-1:0] lanes;
		for (int i = 0; i < utf8e_pkg::LANES; i++) begin
			case ($urandom_range(6))
				0: cps[i] = utf8e_pkg::CP_W'($urandom_range(0, 'h7F));
				1: cps[i] = utf8e_pkg::CP_W'($urandom_range('h80, 'h7FF));
				2: cps[i] = utf8e_pkg::CP_W'($urandom_range('h800, 'hFFFF));
				3: cps[i] = utf8e_pkg::CP_W'($urandom_range('hD800, 'hDFFF));
				4: cps[i] = utf8e_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
				5: cps[i] = utf8e_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF));
				default: cps[i] = utf8e_pkg::CP_W'($urandom);
			endcase
		end
		case ($urandom_range(19))
			0: lanes = '0;
			1: lanes = utf8e_pkg::COUNT_W'($urandom_range(utf8e_pkg::LANES + 1, 15));
			default: lanes = utf8e_pkg::COUNT_W'($urandom_range(1, utf8e_pkg::LANES));
		endcase
		return make_group(cps, lanes);
	endfunction

	task automatic send_group(input utf8e_pkg::group_t g);
		while ($urandom_range(99) < src_idle_pct) begin
			points_if.valid <= 1'b0;
			@(posedge clk);
		end
		points_if.valid   <= 1'b1;
		points_if.payload <= g;
		@(posedge clk);
		while (points_if.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		utf8e_pkg::group_t g;
		int                sent;
		sent = 0;
		while (sent < count) begin
			g = random_group();
			send_group(g);
			if (g.lane_count != 0) sent++;
		end
	endtask

	// stop offering and let every pending chunk come out
	task automatic wait_drained();
		points_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n            <= 1'b0;
		points_if.valid   <= 1'b0;
		points_if.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 32;
		sink_idle_pct = 80;

		send_group(make_group('{default: 21'h0}, 4'd8));
		send_group(make_group('{default: 21'h7F}, 4'd8));
		send_group(make_group('{21'h80, 21'h7FF, 21'h800, 21'hFFFF,
			21'h10000, 21'h10FFFF, 21'h110000, 21'h1FFFFF}, 4'd8));
		send_group(make_group('{default: 21'h1FFFFF}, 4'd8));
		send_group(make_group('{21'hD800, 21'hDFFF, 21'hDBFF, 21'hDC00,
			21'h7F, 21'h80, 21'h0, 21'hFFFD}, 4'd8));
		// zero lanes: ignored
		send_group(make_group('{default: 21'h1FFFFF}, 4'd0));
		// lane counts above eight saturate
		send_group(make_group('{21'h41, 21'h3B1, 21'h20AC, 21'h1F600,
			21'h7FF, 21'h800, 21'h10000, 21'h7F}, 4'd15));
		send_group(make_group('{21'h1F600, 21'h24, 21'hA2, 21'h939,
			21'h10348, 21'hD55C, 21'h1FFFFF, 21'h0}, 4'd9));
		send_group(make_group('{21'h1FFFFF, 21'h7F, 21'h7F, 21'h7F,
			21'h7F, 21'h7F, 21'h7F, 21'h7F}, 4'd1));
		send_group(make_group('{21'h0, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF,
			21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF}, 4'd1));
		send_group(make_group('{21'h41, 21'h3B1, 21'h20AC, 21'h1FFFFF,
			21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF}, 4'd3));
		send_group(make_group('{default: 21'h7FF}, 4'd7));
		send_group(make_group('{21'h7F, 21'h80, 21'h0, 21'h0,
			21'h0, 21'h0, 21'h0, 21'h0}, 4'd2));
		send_group(make_group('{21'h3F, 21'h3F, 21'h3F, 21'h3F,
			21'h3F, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF}, 4'd5));
		send_group(make_group('{default: 21'h1F600}, 4'd4));
		send_group(make_group('{21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA,
			21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA}, 4'd8));
		send_group(make_group('{21'h555, 21'h2AA, 21'h5555, 21'hAAAA,
			21'h55, 21'h2A, 21'h15555, 21'h1AAAA}, 4'd8));

		send_random(34);
		wait_drained();

		src_idle_pct  = 80;
		sink_idle_pct = 32;
		send_random(34);
		wait_drained();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		// long receiver hold-off while groups keep coming
		hold_req <= hold_req + 1;
		send_random(10);
		wait_drained();
		send_random(24);
		wait_drained();

		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
